// ===== rtl/core/lph_pkg.sv =====
// Types and codes shared by the linear probe hash table.
package lph_pkg;

  // Request actions
  localparam logic [1:0] ActLookup = 2'd0;
  localparam logic [1:0] ActInsert = 2'd1;
  localparam logic [1:0] ActDelete = 2'd2;

  // Slot status codes
  localparam logic [1:0] SlotEmpty   = 2'd0;
  localparam logic [1:0] SlotLive    = 2'd1;
  localparam logic [1:0] SlotDeleted = 2'd2;

  // Home hash divider: bits retired per cycle and steps per key
  localparam int DivBits  = 4;
  localparam int DivSteps = 8;

  typedef struct packed {
    logic [1:0]  action;
    logic [30:0] key;
    logic [31:0] payload;
  } req_t;

  typedef struct packed {
    logic        found;
    logic [31:0] read_payload;
    logic [6:0]  entry_total;
    logic        table_full;
    logic        error;
  } rsp_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [30:0] key;
    logic [31:0] payload;
  } slot_t;

  typedef enum logic [5:0] {
    StClear = 6'b000001,
    StIdle  = 6'b000010,
    StHash  = 6'b000100,
    StStart = 6'b001000,
    StProbe = 6'b010000,
    StResp  = 6'b100000
  } state_e;

endpackage

// ===== rtl/core/linear_probe_hash_table.sv =====
// A request passes the home hash divider (DivSteps steps), one memory read issue, one probe
// step per visited slot and one response step; a refused zero-key insert or an unknown action
// goes straight to the response. One request is in flight at a time, so a new one is taken only
// after the previous response is registered; one slot read per cycle while probing.
// Reset clears the count and sets table size to 64, then a clearing pass over all MAX_SLOTS
// slots marks every slot empty; requests are held off until it ends.
module linear_probe_hash_table
  import lph_pkg::*;
#(
  parameter int MAX_SLOTS = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [6:0] cfg_data_i,
  input  logic       req_valid_i,
  output logic       req_ready_o,
  input  req_t       req_i,
  output logic       rsp_valid_o,
  input  logic       rsp_ready_i,
  output rsp_t       rsp_o
);

  localparam int IdxW = $clog2(MAX_SLOTS);
  localparam int CntW = ($clog2(MAX_SLOTS + 1) > 7) ? $clog2(MAX_SLOTS + 1) : 7;

  state_e            state_q, state_d;
  logic [6:0]        cfg_q;
  logic [6:0]        size_eff;
  req_t              req_q;
  logic [31:0]       div_q, div_d;
  logic [6:0]        rem_d;
  logic [2:0]        step_q;
  logic [6:0]        pos_q, pos_next;
  logic [6:0]        n_q;
  logic [CntW-1:0]   cnt_q;
  logic [IdxW-1:0]   clr_idx_q;
  logic              found_q;
  logic [31:0]       rdp_q;
  logic              err_q;
  logic              rsp_valid_q;
  rsp_t              rsp_q;

  slot_t             slot_mem_q [MAX_SLOTS];
  slot_t             rd_q;
  logic              mem_we, mem_re;
  logic [IdxW-1:0]   mem_waddr, mem_raddr;
  slot_t             mem_wdata;

  logic              hit, empty, last, stop;
  logic              ins_commit, del_commit;

  // Effective table size: 0 acts as 1, clipped to the slot count
  always_comb begin
    if (cfg_q == 7'd0) begin
      size_eff = 7'd1;
    end else if (int'(cfg_q) > MAX_SLOTS) begin
      size_eff = 7'(MAX_SLOTS);
    end else begin
      size_eff = cfg_q;
    end
  end

  // Home hash divider: restoring, DivBits quotient bits per cycle
  always_comb begin
    logic [6:0]  r;
    logic [7:0]  r8;
    logic [31:0] dv;
    r  = pos_q;
    dv = div_q;
    for (int i = 0; i < DivBits; i++) begin
      r8 = {r, dv[31]};
      dv = {dv[30:0], 1'b0};
      if (r8 >= {1'b0, size_eff}) begin
        r8 = r8 - {1'b0, size_eff};
      end
      r = r8[6:0];
    end
    rem_d = r;
    div_d = dv;
  end

  // Probe decision on the slot read last cycle
  assign hit      = (rd_q.status == SlotLive) && (rd_q.key == req_q.key);
  assign empty    = (rd_q.status == SlotEmpty);
  assign last     = (n_q == size_eff - 7'd1);
  assign pos_next = (pos_q == size_eff - 7'd1) ? 7'd0 : pos_q + 7'd1;

  always_comb begin
    ins_commit = 1'b0;
    del_commit = 1'b0;
    stop       = 1'b0;
    if (req_q.action == ActInsert) begin
      ins_commit = (rd_q.status != SlotLive);
      stop       = ins_commit || last;
    end else begin
      del_commit = hit && (req_q.action == ActDelete);
      stop       = hit || empty || last;
    end
  end

  // Memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_idx_q;
    mem_wdata = '{status: SlotEmpty, key: '0, payload: '0};
    mem_re    = 1'b0;
    mem_raddr = IdxW'(pos_q);
    case (state_q)
      StClear: begin
        mem_we = 1'b1;
      end
      StStart: begin
        mem_re = 1'b1;
      end
      StProbe: begin
        mem_waddr = IdxW'(pos_q);
        if (ins_commit) begin
          mem_we    = 1'b1;
          mem_wdata = '{status: SlotLive, key: req_q.key, payload: req_q.payload};
        end else if (del_commit) begin
          mem_we    = 1'b1;
          mem_wdata = '{status: SlotDeleted, key: rd_q.key, payload: rd_q.payload};
        end
        if (!stop) begin
          mem_re    = 1'b1;
          mem_raddr = IdxW'(pos_next);
        end
      end
      default: ;
    endcase
  end

  // Slot memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      slot_mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= slot_mem_q[mem_raddr];
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StClear: if (clr_idx_q == IdxW'(MAX_SLOTS - 1)) state_d = StIdle;
      StIdle: begin
        if (req_valid_i) begin
          if ((req_i.action != ActLookup && req_i.action != ActInsert &&
               req_i.action != ActDelete) ||
              (req_i.action == ActInsert && req_i.key == '0)) begin
            state_d = StResp;
          end else begin
            state_d = StHash;
          end
        end
      end
      StHash:  if (step_q == 3'(DivSteps - 1)) state_d = StStart;
      StStart: state_d = StProbe;
      StProbe: if (stop) state_d = StResp;
      StResp:  if (!rsp_valid_q || rsp_ready_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  assign req_ready_o = (state_q == StIdle);

  // Control and datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      cfg_q       <= 7'd64;
      cnt_q       <= '0;
      clr_idx_q   <= '0;
      step_q      <= '0;
      n_q         <= '0;
      pos_q       <= '0;
      div_q       <= '0;
      req_q       <= '0;
      found_q     <= 1'b0;
      rdp_q       <= '0;
      err_q       <= 1'b0;
      rsp_valid_q <= 1'b0;
      rsp_q       <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        cfg_q <= cfg_data_i;
      end
      case (state_q)
        StClear: clr_idx_q <= clr_idx_q + 1'b1;
        StIdle: begin
          if (req_valid_i) begin
            req_q   <= req_i;
            div_q   <= {1'b0, req_i.key};
            pos_q   <= '0;
            step_q  <= '0;
            n_q     <= '0;
            found_q <= 1'b0;
            rdp_q   <= '0;
            err_q   <= (req_i.action == ActInsert);
          end
        end
        StHash: begin
          div_q  <= div_d;
          pos_q  <= rem_d;
          step_q <= step_q + 3'd1;
        end
        StProbe: begin
          if (!stop) begin
            pos_q <= pos_next;
            n_q   <= n_q + 7'd1;
          end
          if (req_q.action == ActInsert) begin
            err_q <= !ins_commit;
            if (ins_commit) cnt_q <= cnt_q + 1'b1;
          end else if (hit) begin
            found_q <= 1'b1;
            if (req_q.action == ActLookup) rdp_q <= rd_q.payload;
            if (del_commit && cnt_q != '0) cnt_q <= cnt_q - 1'b1;
          end
        end
        default: ;
      endcase
      // Output register
      if (state_q == StResp && (!rsp_valid_q || rsp_ready_i)) begin
        rsp_valid_q        <= 1'b1;
        rsp_q.found        <= found_q;
        rsp_q.read_payload <= rdp_q;
        rsp_q.entry_total  <= cnt_q[6:0];
        rsp_q.table_full   <= (cnt_q >= CntW'(size_eff));
        rsp_q.error        <= err_q;
      end else if (rsp_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  // Probe never walks past the table size
  a_probe_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StProbe |-> (n_q < size_eff && pos_q < size_eff))
    else $error("probe past table size");

  // Home slot lies inside the table
  a_home_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StStart |-> pos_q < size_eff)
    else $error("home slot out of range");

  // Live count never exceeds the slot count
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(cnt_q) <= MAX_SLOTS)
    else $error("live count overflow");

  // An accepted request leaves the idle state
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_o |=> state_q != StIdle)
    else $error("request accepted but block idle");

endmodule
